/* sv/rfcc_pkg.sv */
// Shared types and constants for the response frame CRC checker.
package rfcc_pkg;

  localparam logic [15:0] CRC_POLY  = 16'h8005;
  localparam logic [7:0]  MIN_FRAME = 8'd4;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_CRC     = 2'd1,
    VERDICT_BAD_LEN = 2'd2,
    VERDICT_DEV_ERR = 2'd3
  } verdict_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } item_t;

  typedef struct packed {
    logic fire;
    logic emit;
  } fc_status_t;

endpackage

/* sv/rfcc_in_if.sv */
// Input byte channel: valid/ready handshake with a received byte and frame-start flag.
interface rfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

/* sv/rfcc_out_if.sv */
// Result channel: valid/ready handshake carrying payload bytes and frame verdicts.
interface rfcc_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] payload_byte;
  logic [5:0] payload_index;
  logic [1:0] verdict;
  logic       frame_done;

  modport source (output valid, output item_kind, output payload_byte,
                  output payload_index, output verdict, output frame_done,
                  input ready);
  modport sink   (input valid, input item_kind, input payload_byte,
                  input payload_index, input verdict, input frame_done,
                  output ready);
endinterface

/* sv/rfcc_crc_byte.sv */
// One-byte CRC-16 update, polynomial 0x8005, byte fed least significant bit first.
module rfcc_crc_byte (
  input  logic [15:0] crc,
  input  logic [7:0]  data_byte,
  output logic [15:0] crc_next
);

  always_comb begin
    logic [15:0] acc;
    logic        top;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      top = acc[15];
      acc = {acc[14:0], 1'b0};
      if (data_byte[i] != top) begin
        acc = acc ^ rfcc_pkg::CRC_POLY;
      end
    end
    crc_next = acc;
  end

endmodule

/* sv/rfcc_in_stage.sv */
// Input register stage: capture one byte transaction and hold it until taken.
module rfcc_in_stage (
  input  logic                clk,
  input  logic                rst,
  rfcc_in_if.sink             data,
  input  logic                take,
  output rfcc_pkg::item_t     item,
  output logic                vld
);

  assign data.ready = !vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (data.valid && data.ready) begin
      vld <= 1'b1;
    end else if (take) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data.valid && data.ready) begin
      item.rx_byte     <= data.rx_byte;
      item.frame_start <= data.frame_start;
    end
  end

endmodule

/* sv/rfcc_frame_check.sv */
// Frame state, CRC accumulation, verdict decision and result register.
module rfcc_frame_check #(
  parameter int MAX_FRAME = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rfcc_pkg::item_t      item,
  input  logic                 item_vld,
  rfcc_out_if.source           result,
  output logic                 take,
  output rfcc_pkg::fc_status_t status
);

  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  frame_count, frame_count_next;
  logic [15:0] crc_accumulator, crc_accumulator_next;
  logic [7:0]  received_crc_low, received_crc_low_next;
  logic [7:0]  first_payload, first_payload_next;

  logic        out_vld;
  logic        kind, kind_next;
  logic [7:0]  pbyte, pbyte_next;
  logic [5:0]  pidx, pidx_next;
  logic [1:0]  verdict, verdict_next;
  logic        done, done_next;
  logic        emit;

  logic        start;
  logic [15:0] crc_in, crc_out;
  logic [8:0]  pos_plus2;
  logic        match;

  assign take        = item_vld && (!out_vld || result.ready);
  assign status.fire = take;
  assign status.emit = emit;

  assign start     = item.frame_start || (byte_position == 8'd0);
  assign crc_in    = start ? 16'd0 : crc_accumulator;
  assign pos_plus2 = {1'b0, byte_position} + 9'd2;
  assign match     = (received_crc_low == crc_accumulator[7:0]) &&
                     (item.rx_byte == crc_accumulator[15:8]);

  rfcc_crc_byte u_crc (
    .crc       (crc_in),
    .data_byte (item.rx_byte),
    .crc_next  (crc_out)
  );

  always_comb begin
    byte_position_next    = byte_position;
    frame_count_next      = frame_count;
    crc_accumulator_next  = crc_accumulator;
    received_crc_low_next = received_crc_low;
    first_payload_next    = first_payload;
    emit                  = 1'b0;
    kind_next             = rfcc_pkg::KIND_PAYLOAD;
    pbyte_next            = 8'd0;
    pidx_next             = 6'd0;
    verdict_next          = rfcc_pkg::VERDICT_OK;
    done_next             = 1'b0;
    if (start) begin
      crc_accumulator_next  = crc_out;
      received_crc_low_next = 8'd0;
      first_payload_next    = 8'd0;
      if (item.rx_byte < rfcc_pkg::MIN_FRAME || item.rx_byte > 8'(MAX_FRAME)) begin
        frame_count_next   = 8'd0;
        byte_position_next = 8'd0;
        emit               = 1'b1;
        kind_next          = rfcc_pkg::KIND_VERDICT;
        verdict_next       = rfcc_pkg::VERDICT_BAD_LEN;
        done_next          = 1'b1;
      end else begin
        frame_count_next   = item.rx_byte;
        byte_position_next = 8'd1;
      end
    end else if (pos_plus2 < {1'b0, frame_count}) begin
      crc_accumulator_next = crc_out;
      if (byte_position == 8'd1) begin
        first_payload_next = item.rx_byte;
      end
      byte_position_next = byte_position + 8'd1;
      emit               = 1'b1;
      pbyte_next         = item.rx_byte;
      pidx_next          = 6'(byte_position - 8'd1);
    end else if (pos_plus2 == {1'b0, frame_count}) begin
      received_crc_low_next = item.rx_byte;
      byte_position_next    = byte_position + 8'd1;
    end else begin
      byte_position_next = 8'd0;
      emit               = 1'b1;
      kind_next          = rfcc_pkg::KIND_VERDICT;
      done_next          = 1'b1;
      if (!match) begin
        verdict_next = rfcc_pkg::VERDICT_CRC;
      end else if (frame_count == rfcc_pkg::MIN_FRAME && first_payload != 8'd0) begin
        verdict_next = rfcc_pkg::VERDICT_DEV_ERR;
      end else begin
        verdict_next = rfcc_pkg::VERDICT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= 8'd0;
      frame_count      <= 8'd0;
      crc_accumulator  <= 16'd0;
      received_crc_low <= 8'd0;
      first_payload    <= 8'd0;
      out_vld          <= 1'b0;
    end else begin
      if (take) begin
        byte_position    <= byte_position_next;
        frame_count      <= frame_count_next;
        crc_accumulator  <= crc_accumulator_next;
        received_crc_low <= received_crc_low_next;
        first_payload    <= first_payload_next;
      end
      if (take && emit) begin
        out_vld <= 1'b1;
      end else if (result.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      kind    <= kind_next;
      pbyte   <= pbyte_next;
      pidx    <= pidx_next;
      verdict <= verdict_next;
      done    <= done_next;
    end
  end

  assign result.valid         = out_vld;
  assign result.item_kind     = kind;
  assign result.payload_byte  = pbyte;
  assign result.payload_index = pidx;
  assign result.verdict       = verdict;
  assign result.frame_done    = done;

endmodule

/* sv/response_frame_crc_checker.sv */
// Response frame CRC checker top level: input register, frame check and result register.
//
// Takes one received byte per transaction and checks frames whose first byte counts the
// whole frame, running a CRC-16 (0x8005, zero init, LSB first) over all but the last two
// bytes, which must carry the CRC low byte first. Payload bytes come out as they arrive;
// the last byte of a frame, or a count below 4 or above MAX_FRAME, gives one verdict
// transaction. A byte flagged frame_start drops any frame in progress. One byte is taken
// every cycle while results drain; a byte's result goes from the input register through the
// combinational CRC byte update into the result register. A result held by the receiver
// stalls the input register, and then the input.
module response_frame_crc_checker #(
  parameter int MAX_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst,
  rfcc_in_if.sink     data,
  rfcc_out_if.source  result
);

  rfcc_pkg::item_t      item;
  logic                 item_vld;
  logic                 take;
  rfcc_pkg::fc_status_t status;

  rfcc_in_stage u_in_stage (
    .clk  (clk),
    .rst  (rst),
    .data (data),
    .take (take),
    .item (item),
    .vld  (item_vld)
  );

  rfcc_frame_check #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame_check (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .item_vld (item_vld),
    .result   (result),
    .take     (take),
    .status   (status)
  );

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !item_vld |-> data.ready)
    else $error("input not ready while input register empty");

  a_emit_shows_result: assert property (@(posedge clk) disable iff (rst)
    status.fire && status.emit |=> result.valid)
    else $error("emitted transaction not presented");

endmodule
